FILE: src/hmac_pkg.sv
// ----------------------------------------------------------------------------
// HMAC-SHA256 package
// Shared types, constants and round functions for the HMAC-SHA256 engine.
// ----------------------------------------------------------------------------
package hmac_pkg;

   localparam int LENGTH_BITS_DEFAULT = 64;
   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5c;
   localparam int BLOCK_BYTES = 64;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Control from the sequencer to the compression unit.
   typedef struct packed {
      logic start;
      logic init;
   } comp_ctl_type;

   // Status from the compression unit.
   typedef struct packed {
      logic busy;
      logic done;
   } comp_sts_type;

   localparam logic [255:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] sha_k(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

FILE: src/hmac_comp.sv
// ----------------------------------------------------------------------------
// HMAC-SHA256 compression unit
// One SHA-256 round a cycle over a 16-word rolling schedule; 64 rounds, then
// the final chaining add.
// ----------------------------------------------------------------------------
module hmac_comp
   import hmac_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  comp_ctl_type  ctl,
   input  logic [511:0]  block,
   output comp_sts_type  sts,
   output logic [255:0]  hash
);

   logic [255:0] h_ff, h_in;
   logic [255:0] v_ff, v_in;
   logic [511:0] w_ff, w_in;
   logic [6:0]   t_ff, t_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   logic [31:0] a, b, c, d, e, f, g, hh, wt, w1, w14, w9, w0, s0, s1;
   logic [31:0] t1, t2;

   always_comb begin
      {a, b, c, d, e, f, g, hh} = v_ff;
      // Word zero of the window sits in the top bits.
      w0  = w_ff[511:480];
      w1  = w_ff[479:448];
      w9  = w_ff[223:192];
      w14 = w_ff[63:32];
      s0  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
      s1  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
      wt  = w0;
      t1  = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
            + sha_k(t_ff[5:0]) + wt;
      t2  = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

      h_in    = h_ff;
      v_in    = v_ff;
      w_in    = w_ff;
      t_in    = t_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.init) begin
         h_in = SHA_IV;
      end
      if (ctl.start) begin
         busy_in = 1'b1;
         t_in    = '0;
         v_in    = ctl.init ? SHA_IV : h_ff;
         w_in    = block;
      end else if (busy_ff) begin
         if (t_ff == 7'd64) begin
            // Chaining add, one lane per word.
            for (int j = 0; j < 8; j++) begin
               h_in[255 - 32*j -: 32] = h_ff[255 - 32*j -: 32] + v_ff[255 - 32*j -: 32];
            end
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            v_in = {t1 + t2, a, b, c, d + t1, e, f, g};
            w_in = {w_ff[479:0], w0 + s0 + w9 + s1};
            t_in = t_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         t_ff    <= '0;
         h_ff    <= SHA_IV;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         t_ff    <= t_in;
         h_ff    <= h_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign hash     = h_ff;

endmodule

FILE: src/hmac_sha256_engine_core.sv
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine, top level
// Streams a key then a message and returns the eight digest words.
// ----------------------------------------------------------------------------
// Byte requests are taken only while the engine is idle. A request that
// completes a 64-byte block holds stall high while the shared round unit
// runs the compression, one round a cycle. The key end costs up to four
// compressions and the message end up to five, after which the eight digest
// words leave one a cycle while the result side does not stall.
module hmac_sha256_engine_core
   import hmac_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_COMP  = 8'b00000010,
      ST_WAIT  = 8'b00000100,
      ST_OUT   = 8'b00001000,
      ST_PAD   = 8'b00010000,
      ST_LEN   = 8'b00100000,
      ST_NEXT  = 8'b01000000,
      ST_SPARE = 8'b10000000
   } state_type;

   // Sequencer step codes for what follows a compression.
   typedef enum logic [3:0] {
      NX_NONE, NX_KEYFIN, NX_KEYLOAD, NX_IPAD, NX_MSGFIN, NX_OPAD, NX_OUTER,
      NX_DONE, NX_LENONLY
   } next_type;

   state_type    state_ff, state_in;
   next_type     nx_ff, nx_in;
   logic [511:0] key_ff, key_in;
   logic [511:0] buf_ff, buf_in;
   logic [63:0]  kcnt_ff, kcnt_in;
   logic [63:0]  mcnt_ff, mcnt_in;
   logic         phase_ff, phase_in;
   logic [255:0] inner_ff, inner_in;
   logic [63:0]  len_ff, len_in;
   logic [2:0]   oidx_ff, oidx_in;
   logic [255:0] res_ff, res_in;

   comp_ctl_type ctl;
   comp_sts_type sts;
   logic [511:0] blk;
   logic [255:0] hash;
   logic         acc;
   logic [LENGTH_BITS-1:0] bits;

   hmac_comp u_comp (
      .clock (clock), .reset (reset), .ctl (ctl), .block (blk),
      .sts (sts), .hash (hash)
   );

   assign acc = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   function automatic logic [511:0] put_byte(input logic [511:0] v, input logic [5:0] i,
                                              input logic [7:0] x);
      logic [511:0] r;
      r = v;
      r[511 - 8*i -: 8] = x;
      return r;
   endfunction

   // Marker byte at fill, zeros after it.
   function automatic logic [511:0] pad_at(input logic [511:0] v, input logic [5:0] fill);
      logic [511:0] r;
      r = v;
      for (int j = 0; j < 64; j++) begin
         if (j == fill) r[511 - 8*j -: 8] = 8'h80;
         else if (j > fill) r[511 - 8*j -: 8] = 8'h00;
      end
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      nx_in    = nx_ff;
      key_in   = key_ff;
      buf_in   = buf_ff;
      kcnt_in  = kcnt_ff;
      mcnt_in  = mcnt_ff;
      phase_in = phase_ff;
      inner_in = inner_ff;
      len_in   = len_ff;
      oidx_in  = oidx_ff;
      res_in   = res_ff;
      ctl      = '0;
      blk      = buf_ff;
      bits     = len_ff[LENGTH_BITS-1:0] << 3;

      case (state_ff)
         ST_IDLE: begin
            if (acc && req_data.action == phase_ff) begin
               if (!phase_ff) begin
                  // Key bytes.
                  logic [63:0] kc;
                  kc = kcnt_ff;
                  if (req_data.byte_valid) begin
                     if (kcnt_ff < 64'd64) begin
                        key_in = put_byte(key_ff, kcnt_ff[5:0], req_data.data_byte);
                     end else begin
                        buf_in = put_byte(buf_ff, kcnt_ff[5:0], req_data.data_byte);
                     end
                     kc = kcnt_ff + 64'd1;
                     kcnt_in = kc;
                  end
                  if (req_data.byte_valid && kcnt_ff == 64'd64) begin
                     // First key block: hash the stored 64 bytes.
                     ctl.start = 1'b1; ctl.init = 1'b1; blk = key_ff;
                     nx_in = NX_NONE; state_in = ST_COMP;
                     if (req_data.last) nx_in = NX_KEYFIN;
                  end else if (req_data.byte_valid && kcnt_ff > 64'd64 &&
                               kcnt_ff[5:0] == 6'd63) begin
                     ctl.start = 1'b1; blk = buf_in;
                     nx_in = req_data.last ? NX_KEYFIN : NX_NONE; state_in = ST_COMP;
                  end else if (req_data.last) begin
                     state_in = ST_NEXT;
                     nx_in = (kc > 64'd64) ? NX_KEYFIN : NX_IPAD;
                  end
               end else begin
                  logic [63:0] mc;
                  mc = mcnt_ff;
                  if (req_data.byte_valid) begin
                     buf_in = put_byte(buf_ff, mcnt_ff[5:0], req_data.data_byte);
                     mc = mcnt_ff + 64'd1;
                     mcnt_in = mc;
                  end
                  if (req_data.byte_valid && mc[5:0] == 6'd0) begin
                     ctl.start = 1'b1; blk = buf_in; state_in = ST_COMP;
                     nx_in = req_data.last ? NX_MSGFIN : NX_NONE;
                  end else if (req_data.last) begin
                     state_in = ST_NEXT; nx_in = NX_MSGFIN;
                  end
               end
            end
         end
         ST_COMP: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.done) state_in = (nx_ff == NX_NONE) ? ST_IDLE : ST_NEXT;
         end
         ST_NEXT: begin
            // Steps of a finishing sequence; the key and message ends pad the tail into the buffer.
            case (nx_ff)
               NX_KEYFIN: begin
                  len_in = kcnt_ff; buf_in = pad_at(buf_ff, kcnt_ff[5:0]);
                  nx_in = NX_KEYLOAD; state_in = ST_PAD;
               end
               NX_KEYLOAD: begin
                  key_in = {hash, 256'd0}; nx_in = NX_IPAD; state_in = ST_NEXT;
               end
               NX_IPAD: begin
                  for (int j = 0; j < 64; j++)
                     blk[511 - 8*j -: 8] = key_ff[511 - 8*j -: 8] ^ IPAD;
                  ctl.start = 1'b1; ctl.init = 1'b1;
                  phase_in = 1'b1; mcnt_in = '0;
                  nx_in = NX_NONE; state_in = ST_COMP;
               end
               NX_MSGFIN: begin
                  len_in = mcnt_ff + 64'd64; buf_in = pad_at(buf_ff, mcnt_ff[5:0]);
                  nx_in = NX_OPAD; state_in = ST_PAD;
               end
               NX_OPAD: begin
                  inner_in = hash;
                  for (int j = 0; j < 64; j++)
                     blk[511 - 8*j -: 8] = key_ff[511 - 8*j -: 8] ^ OPAD;
                  ctl.start = 1'b1; ctl.init = 1'b1;
                  nx_in = NX_OUTER; state_in = ST_COMP;
               end
               NX_OUTER: begin
                  buf_in = pad_at({inner_ff, 256'd0}, 6'd32);
                  len_in = 64'd96; nx_in = NX_DONE; state_in = ST_LEN;
               end
               NX_DONE: begin
                  res_in = hash; oidx_in = '0; state_in = ST_OUT;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_PAD: begin
            // If the marker reached the length field, one extra block.
            if (len_ff[5:0] >= 6'd56) begin
               ctl.start = 1'b1; state_in = ST_COMP; nx_in = NX_LENONLY;
               blk = buf_ff;
               buf_in = '0;
               len_in = len_ff;
            end else begin
               state_in = ST_LEN;
            end
            // Remember where to go after the length block.
            if (len_ff[5:0] >= 6'd56) nx_in = nx_ff;
         end
         ST_LEN: begin
            blk = buf_ff;
            blk[63:0] = 64'(bits);
            ctl.start = 1'b1; state_in = ST_COMP;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  state_in = ST_IDLE; phase_in = 1'b0;
                  kcnt_in = '0; mcnt_in = '0; key_in = '0;
                  ctl.init = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // After a pad-overflow block the length block follows.
   logic pad_pending_ff, pad_pending_in;
   state_type state_q;
   always_comb begin
      state_q = state_in;
      if (state_ff == ST_WAIT && sts.done && pad_pending_ff) state_q = ST_LEN;
   end

   assign pad_pending_in = (state_ff == ST_PAD) ? (len_ff[5:0] >= 6'd56)
                         : (state_ff == ST_LEN) ? 1'b0 : pad_pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         nx_ff          <= NX_NONE;
         phase_ff       <= 1'b0;
         kcnt_ff        <= '0;
         mcnt_ff        <= '0;
         key_ff         <= '0;
         oidx_ff        <= '0;
         pad_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_q;
         nx_ff          <= nx_in;
         phase_ff       <= phase_in;
         kcnt_ff        <= kcnt_in;
         mcnt_ff        <= mcnt_in;
         key_ff         <= key_in;
         oidx_ff        <= oidx_in;
         pad_pending_ff <= pad_pending_in;
      end
      buf_ff   <= buf_in;
      inner_ff <= inner_in;
      len_ff   <= len_in;
      res_ff   <= res_in;
   end

   assign rsp_valid            = (state_ff == ST_OUT);
   assign rsp_data.digest_word = res_ff[255 - 32*oidx_ff -: 32];
   assign rsp_data.word_index  = oidx_ff;
   assign rsp_data.last_word   = (oidx_ff == 3'd7);

   // The result channel is only active while no request is taken.
   a_out_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("result while taking requests");

   // The round unit is never started while it is still busy.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !sts.busy) else $error("round unit restarted while busy");

   // A final word leaves the block idle on the next cycle.
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_word) |=> !req_stall)
      else $error("block not idle after last word");

endmodule

FILE: tb/hmac_sha256_engine_core_tb.sv
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine testbench
// Streams keys and messages of many lengths into the engine, including empty,
// block-sized and over-long keys, stray and empty requests, and checks every
// digest word against a self-contained HMAC-SHA256 predictor.
// ----------------------------------------------------------------------------
module hmac_sha256_engine_core_tb;
   import hmac_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_REPORTS = 10;
   localparam logic ACT_KEY = 1'b0;
   localparam logic ACT_MSG = 1'b1;

   typedef logic [7:0] byte_block_type [64];

   // Keeps its own HMAC-SHA256 state and the queue of digest words still owed.
   class digest_scoreboard;
      logic [31:0] round_k [64] = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      logic [31:0] start_words [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
         32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

      byte_block_type key_bytes;
      byte_block_type fill_bytes;
      logic [31:0] chain [8];
      logic [31:0] inner_words [8];
      logic [63:0] key_len;
      logic [63:0] msg_len;
      bit          in_message;
      rsp_type     owed_words [$];
      int          failures;

      function new();
         failures = 0;
         clear();
      endfunction

      function void clear();
         foreach (key_bytes[j]) key_bytes[j] = 8'h00;
         foreach (fill_bytes[j]) fill_bytes[j] = 8'h00;
         foreach (inner_words[j]) inner_words[j] = 32'h0;
         chain = start_words;
         key_len = 64'd0;
         msg_len = 64'd0;
         in_message = 1'b0;
      endfunction

      function logic [31:0] rotr(input logic [31:0] x, input int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // One SHA-256 compression of a 64-byte block into the chaining words.
      function void compress(input byte_block_type b);
         logic [31:0] w [64];
         logic [31:0] v [8];
         logic [31:0] s0, s1, t1, t2;
         for (int j = 0; j < 16; j++)
            w[j] = {b[4*j], b[4*j+1], b[4*j+2], b[4*j+3]};
         for (int j = 16; j < 64; j++) begin
            s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
            s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
            w[j] = w[j-16] + s0 + w[j-7] + s1;
         end
         v = chain;
         for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int j = 0; j < 8; j++) chain[j] += v[j];
      endfunction

      // Appends the padding and the bit length, compressing one or two blocks.
      function void finish(input int unsigned fill, input logic [63:0] total);
         logic [63:0] bits;
         bits = total << 3;
         fill = fill & 63;
         fill_bytes[fill] = 8'h80;
         for (int j = fill + 1; j < 64; j++) fill_bytes[j] = 8'h00;
         if (fill >= 56) begin
            compress(fill_bytes);
            foreach (fill_bytes[j]) fill_bytes[j] = 8'h00;
         end
         for (int j = 0; j < 8; j++) fill_bytes[56+j] = bits[63-8*j -: 8];
         compress(fill_bytes);
      endfunction

      // Restarts the hash with the padded key XORed with the given pad byte.
      function void start_with_pad(input logic [7:0] pad);
         byte_block_type b;
         foreach (b[j]) b[j] = key_bytes[j] ^ pad;
         chain = start_words;
         compress(b);
      endfunction

      // Advances the prediction by one accepted request.
      function void note_request(input req_type r);
         rsp_type word;
         if (r.action != in_message) return;
         if (!in_message) begin
            if (r.byte_valid) begin
               if (key_len < 64) begin
                  key_bytes[key_len[5:0]] = r.data_byte;
               end else begin
                  if (key_len == 64) begin
                     chain = start_words;
                     compress(key_bytes);
                  end
                  fill_bytes[key_len[5:0]] = r.data_byte;
                  if (key_len[5:0] == 6'd63) compress(fill_bytes);
               end
               key_len++;
            end
            if (r.last) begin
               // Over-long keys are replaced by their own digest.
               if (key_len > 64) begin
                  finish(key_len[5:0], key_len);
                  foreach (key_bytes[j]) key_bytes[j] = 8'h00;
                  for (int j = 0; j < 32; j++)
                     key_bytes[j] = chain[j/4][31-8*(j%4) -: 8];
               end
               start_with_pad(8'h36);
               msg_len = 64'd0;
               in_message = 1'b1;
            end
            return;
         end
         if (r.byte_valid) begin
            fill_bytes[msg_len[5:0]] = r.data_byte;
            msg_len++;
            if (msg_len[5:0] == 6'd0) compress(fill_bytes);
         end
         if (!r.last) return;
         finish(msg_len[5:0], msg_len + 64);
         inner_words = chain;
         start_with_pad(8'h5c);
         for (int j = 0; j < 32; j++)
            fill_bytes[j] = inner_words[j/4][31-8*(j%4) -: 8];
         finish(32, 64'd96);
         for (int j = 0; j < 8; j++) begin
            word.digest_word = chain[j];
            word.word_index = j[2:0];
            word.last_word = (j == 7);
            owed_words.push_back(word);
         end
         clear();
      endfunction

      // Compares one accepted digest word with the oldest one owed.
      function void check_result(input rsp_type got);
         rsp_type want;
         if (owed_words.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("Unexpected digest word %h index %0d last %0b",
                        got.digest_word, got.word_index, got.last_word);
            return;
         end
         want = owed_words.pop_front();
         if (got.digest_word !== want.digest_word || got.word_index !== want.word_index
             || got.last_word !== want.last_word) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("Digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                        want.digest_word, want.word_index, want.last_word,
                        got.digest_word, got.word_index, got.last_word);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   digest_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   int requests_sent;
   int cycles;

   hmac_sha256_engine_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog on the total run length.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus a long hold-off when one is requested.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // Sample accepted digest words.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // Sends one request; entered and left at a falling edge.
   task automatic send_req(input logic act, input logic [7:0] d, input logic bv,
                           input logic lst);
      req_type r;
      r.action = act;
      r.data_byte = d;
      r.byte_valid = bv;
      r.last = lst;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      requests_sent++;
      // Idling mix follows progress through the run.
      if (requests_sent < 117) begin
         send_idle_pct = 16; recv_idle_pct = 61;
      end else if (requests_sent < 234) begin
         send_idle_pct = 61; recv_idle_pct = 16;
      end else begin
         send_idle_pct = 0; recv_idle_pct = 0;
      end
      @(negedge clock);
   endtask

   // Sends a stream of bytes, with occasional stray or empty requests mixed in when noisy.
   task automatic send_stream(input logic act, input int len, input bit noisy);
      bit tail_empty;
      tail_empty = (len == 0) || $urandom_range(0, 1);
      for (int j = 0; j < len; j++) begin
         if (noisy && $urandom_range(0, 15) == 0) begin
            if ($urandom_range(0, 1))
               send_req(~act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            else
               send_req(act, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_req(act, 8'($urandom_range(0, 255)), 1'b1, (j == len - 1) && !tail_empty);
      end
      if (tail_empty) send_req(act, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   function automatic int pick_len(input bit is_key);
      case ($urandom_range(0, 9))
         0: return 0;
         1: return is_key ? 64 : $urandom_range(55, 64);
         2: return is_key ? $urandom_range(65, 140) : $urandom_range(100, 200);
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      hold_left = 0;
      requests_sent = 0;
      send_idle_pct = 16;
      recv_idle_pct = 61;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed: stray message request, empty request, empty key, stray key request, empty request, empty message.
      send_req(ACT_MSG, 8'hff, 1'b1, 1'b1);
      send_req(ACT_KEY, 8'h00, 1'b0, 1'b0);
      send_req(ACT_KEY, 8'h00, 1'b0, 1'b1);
      send_req(ACT_KEY, 8'hff, 1'b1, 1'b1);
      send_req(ACT_MSG, 8'h00, 1'b0, 1'b0);
      send_req(ACT_MSG, 8'h00, 1'b0, 1'b1);
      // One-byte key and message carried on their closing requests.
      send_req(ACT_KEY, 8'hff, 1'b1, 1'b1);
      send_req(ACT_MSG, 8'h00, 1'b1, 1'b1);
      send_req(ACT_KEY, 8'h00, 1'b1, 1'b1);
      send_req(ACT_MSG, 8'hff, 1'b1, 1'b1);
      // Exactly one block of key, then a key just over one block. The result
      // side holds off meanwhile, so the next key backs up behind the digest.
      send_stream(ACT_KEY, 64, 0);
      hold_left = 600;
      send_stream(ACT_MSG, 56, 0);
      send_stream(ACT_KEY, 65, 0);
      send_stream(ACT_MSG, 64, 0);
      // Let the engine drain completely before carrying on.
      req_valid = 1'b0;
      while (sb.owed_words.size() != 0) @(negedge clock);

      // Random streams with noise.
      while (requests_sent < 350) begin
         send_stream(ACT_KEY, pick_len(1), 1);
         send_stream(ACT_MSG, pick_len(0), 1);
      end
      req_valid = 1'b0;

      while (sb.owed_words.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
